FILE: design/prsp_pkg.sv
package prsp_pkg;

    // Message layout
    localparam int MAX_TEXT_LEN = 512;
    localparam int HEADER_BYTES = 26;
    localparam int LEN_W        = 10;

    // Reset value of the record limit
    localparam logic [15:0] MAX_RECORDS_RESET = 16'd4096;

    // Result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;

    // Status codes
    localparam logic [2:0] STATUS_BUSY      = 3'd0;
    localparam logic [2:0] STATUS_OK        = 3'd1;
    localparam logic [2:0] STATUS_COUNT_BIG = 3'd2;
    localparam logic [2:0] STATUS_BAD_VALUE = 3'd3;
    localparam logic [2:0] STATUS_TEXT_LONG = 3'd4;
    localparam logic [2:0] STATUS_TRUNC     = 3'd5;
    localparam logic [2:0] STATUS_TRAILING  = 3'd6;

    // One result beat
    typedef struct packed {
        logic [1:0]        item_kind;
        logic [31:0]       record_id;
        logic signed [31:0] step_total;
        logic [31:0]       flag_bits;
        logic [31:0]       current_value;
        logic [31:0]       default_value;
        logic [LEN_W-1:0]  title_length;
        logic [LEN_W-1:0]  short_length;
        logic [LEN_W-1:0]  unit_length;
        logic [7:0]        text_byte;
        logic [1:0]        text_field;
        logic [2:0]        status;
    } prsp_result_t;

endpackage

FILE: design/prsp_core.sv
module prsp_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  logic [15:0]           max_records,
    output prsp_pkg::prsp_result_t result
);

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_HEADER,
        PH_TITLE,
        PH_SHORT,
        PH_UNIT,
        PH_DONE,
        PH_FAILED
    } phase_t;

    localparam logic [1:0] TEXT_NONE = 2'd3;

    phase_t                        phase_reg, phase_next;
    logic [4:0]                    pos_reg, pos_next;
    logic [31:0]                   total_reg, total_next;
    logic [15:0]                   done_reg, done_next;
    logic [31:0]                   field_reg [5];
    logic [31:0]                   field_next [5];
    logic [prsp_pkg::LEN_W-1:0]    hold_reg [3];
    logic [prsp_pkg::LEN_W-1:0]    hold_next [3];
    logic [prsp_pkg::LEN_W-1:0]    rem_reg, rem_next;
    logic [2:0]                    err_reg, err_next;
    logic                          over_reg, over_next;

    logic [2:0]  word_sel;
    logic [1:0]  lane;
    logic [4:0]  len_ofs;
    logic [1:0]  len_sel;
    logic [15:0] len_full;
    logic        nt_req;
    logic [1:0]  nt_start;
    logic [1:0]  nt_pick;
    logic [2:0]  hold_nz;
    logic [16:0] done_inc;

    // Accept values that are zero of either sign or lie in 0..1
    function automatic logic value_ok(input logic [31:0] bits);
        value_ok = (bits[30:0] == 31'd0) || (bits <= 32'h3F80_0000);
    endfunction

    // First text at or after start with a nonzero length
    function automatic logic [1:0] pick_text(input logic [2:0] nz, input logic [1:0] start);
        logic [1:0] sel;
        sel = TEXT_NONE;
        for (int i = 2; i >= 0; i--) begin
            if (nz[i] && (2'(i) >= start)) begin
                sel = 2'(i);
            end
        end
        pick_text = sel;
    endfunction

    // Next state and result for one byte
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        done_next  = done_reg;
        field_next = field_reg;
        hold_next  = hold_reg;
        rem_next   = rem_reg;
        err_next   = err_reg;
        over_next  = over_reg;
        result     = '0;
        nt_req     = 1'b0;
        nt_start   = 2'd0;
        word_sel   = pos_reg[4:2];
        lane       = pos_reg[1:0];
        len_ofs    = pos_reg - 5'd20;
        len_sel    = len_ofs[2:1];
        len_full   = {in_byte, hold_reg[len_sel][7:0]};
        hold_nz    = 3'd0;
        nt_pick    = TEXT_NONE;
        done_inc   = {1'b0, done_reg} + 17'd1;

        unique case (phase_reg)
            PH_COUNT: begin
                total_next[{lane, 3'b000} +: 8] = in_byte;
                pos_next = pos_reg + 5'd1;
                if (lane == 2'd3) begin
                    pos_next = 5'd0;
                    if (total_next > {16'd0, max_records}) begin
                        err_next   = prsp_pkg::STATUS_COUNT_BIG;
                        phase_next = PH_FAILED;
                    end else if (total_next == 32'd0) begin
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            PH_HEADER: begin
                if (pos_reg < 5'd20) begin
                    // assemble one header word
                    field_next[word_sel][{lane, 3'b000} +: 8] = in_byte;
                    if (lane == 2'd3 && word_sel >= 3'd3 &&
                        !value_ok(field_next[word_sel])) begin
                        err_next   = prsp_pkg::STATUS_BAD_VALUE;
                        phase_next = PH_FAILED;
                    end
                end else if (!pos_reg[0]) begin
                    hold_next[len_sel] = {2'b00, in_byte};
                end else if (len_full > 16'(prsp_pkg::MAX_TEXT_LEN)) begin
                    // oversized length: remember, check at end of header
                    over_next          = 1'b1;
                    hold_next[len_sel] = '0;
                end else begin
                    hold_next[len_sel] = len_full[prsp_pkg::LEN_W-1:0];
                end
                if (phase_next == PH_HEADER) begin
                    pos_next = pos_reg + 5'd1;
                    if (pos_reg == 5'(prsp_pkg::HEADER_BYTES - 1)) begin
                        if (over_next) begin
                            err_next   = prsp_pkg::STATUS_TEXT_LONG;
                            phase_next = PH_FAILED;
                        end else begin
                            result.item_kind     = prsp_pkg::KIND_HEADER;
                            result.record_id     = field_next[0];
                            result.step_total    = field_next[1];
                            result.flag_bits     = field_next[2];
                            result.current_value = field_next[3];
                            result.default_value = field_next[4];
                            result.title_length  = hold_next[0];
                            result.short_length  = hold_next[1];
                            result.unit_length   = hold_next[2];
                            nt_req   = 1'b1;
                            nt_start = 2'd0;
                        end
                    end
                end
            end
            PH_TITLE, PH_SHORT, PH_UNIT: begin
                result.item_kind  = prsp_pkg::KIND_TEXT;
                result.text_byte  = in_byte;
                unique case (phase_reg)
                    PH_TITLE: result.text_field = 2'd0;
                    PH_SHORT: result.text_field = 2'd1;
                    default:  result.text_field = 2'd2;
                endcase
                if (rem_reg != '0) begin
                    rem_next = rem_reg - 10'd1;
                end
                if (rem_next == '0) begin
                    nt_req   = 1'b1;
                    nt_start = result.text_field + 2'd1;
                end
            end
            PH_DONE: begin
                err_next   = prsp_pkg::STATUS_TRAILING;
                phase_next = PH_FAILED;
            end
            default: begin
                // failed: drop bytes until the last one
            end
        endcase

        // Move on to the next text, or close the record
        if (nt_req) begin
            hold_nz[0] = (hold_next[0] != '0);
            hold_nz[1] = (hold_next[1] != '0);
            hold_nz[2] = (hold_next[2] != '0);
            nt_pick    = pick_text(hold_nz, nt_start);
            unique case (nt_pick)
                2'd0: begin
                    phase_next = PH_TITLE;
                    rem_next   = hold_next[0];
                end
                2'd1: begin
                    phase_next = PH_SHORT;
                    rem_next   = hold_next[1];
                end
                2'd2: begin
                    phase_next = PH_UNIT;
                    rem_next   = hold_next[2];
                end
                default: begin
                    done_next  = done_inc[15:0];
                    over_next  = 1'b0;
                    pos_next   = 5'd0;
                    phase_next = ({15'd0, done_inc} >= total_reg) ? PH_DONE : PH_HEADER;
                end
            endcase
        end

        // Close the message on the last beat
        if (in_last) begin
            if (err_next == prsp_pkg::STATUS_BUSY && phase_next != PH_DONE) begin
                err_next = (phase_next == PH_TITLE || phase_next == PH_SHORT ||
                            phase_next == PH_UNIT) ? prsp_pkg::STATUS_TEXT_LONG
                                                   : prsp_pkg::STATUS_TRUNC;
            end
            result.status = (err_next != prsp_pkg::STATUS_BUSY) ? err_next
                                                                : prsp_pkg::STATUS_OK;
            phase_next = PH_COUNT;
            pos_next   = 5'd0;
            done_next  = 16'd0;
            rem_next   = '0;
            err_next   = prsp_pkg::STATUS_BUSY;
            over_next  = 1'b0;
        end else begin
            result.status = err_next;
        end
    end

    // Hold parser state; advance one byte per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_COUNT;
            pos_reg   <= 5'd0;
            done_reg  <= 16'd0;
            rem_reg   <= '0;
            err_reg   <= prsp_pkg::STATUS_BUSY;
            over_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            done_reg  <= done_next;
            rem_reg   <= rem_next;
            err_reg   <= err_next;
            over_reg  <= over_next;
        end
    end

    // Assembly registers are fully rewritten before use
    always_ff @(posedge aclk) begin
        if (step_en) begin
            total_reg <= total_next;
            field_reg <= field_next;
            hold_reg  <= hold_next;
        end
    end

    a_err_iff_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != prsp_pkg::STATUS_BUSY) == (phase_reg == PH_FAILED))
        else $error("sticky error and failed phase disagree");

    a_text_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TITLE || phase_reg == PH_SHORT || phase_reg == PH_UNIT)
        |-> (rem_reg != '0))
        else $error("text phase with no bytes remaining");

    a_records_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER || phase_reg == PH_TITLE || phase_reg == PH_SHORT ||
         phase_reg == PH_UNIT) |-> ({16'd0, done_reg} < total_reg))
        else $error("record in progress beyond the record count");

endmodule

FILE: design/parameter_record_stream_parser.sv
// An accepted input beat is held in the input register; its result beat is then
// registered in the result register when that register is free or being taken.
// Throughput: one byte per cycle while results are taken, one result beat per byte; the
// parser's next-state and result logic is combinational between the input and result registers.
// Reset: aresetn (synchronous, active low) returns the parser to the count
// header, empties both registers and sets max_records to 4096.
module parameter_record_stream_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    input  logic         s_tlast,   // is_last
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] record_id, [63:32] step_total, [95:64] flag_bits,
    // [127:96] current_value, [159:128] default_value, [169:160] title_length,
    // [179:170] short_length, [189:180] unit_length, [197:190] text_byte,
    // [200:198] status, [207:201] zero
    output logic [207:0] m_tdata,
    output logic [3:0]   m_tuser,   // [1:0] item_kind, [3:2] text_field
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data   // max_records
);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_last_reg;
    logic                    out_valid_reg;
    prsp_pkg::prsp_result_t  out_reg;
    prsp_pkg::prsp_result_t  result;
    logic [15:0]             max_records_reg;
    logic                    advance;
    logic                    step_en;

    assign advance   = !out_valid_reg || m_tready;
    assign step_en   = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    prsp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .in_byte     (in_byte_reg),
        .in_last     (in_last_reg),
        .max_records (max_records_reg),
        .result      (result)
    );

    // Record limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_records_reg <= prsp_pkg::MAX_RECORDS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_records_reg <= cfg_data;
        end
    end

    // Input register: load a beat whenever the stage is free or moving on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.text_field, out_reg.item_kind};
    assign m_tdata  = {7'd0,
                       out_reg.status,
                       out_reg.text_byte,
                       out_reg.unit_length,
                       out_reg.short_length,
                       out_reg.title_length,
                       out_reg.default_value,
                       out_reg.current_value,
                       out_reg.flag_bits,
                       out_reg.step_total,
                       out_reg.record_id};

    a_last_has_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && in_last_reg) |=> (out_reg.status != prsp_pkg::STATUS_BUSY))
        else $error("final beat left status in progress");

    a_text_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.item_kind != prsp_pkg::KIND_TEXT) |->
        (out_reg.text_byte == 8'd0 && out_reg.text_field == 2'd0))
        else $error("text fields set on a non-text beat");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg) |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule
